// File: rtl/core/slink_pkg.sv
// Shared types, constants and codes for the single-linkage pointer core.
package slink_pkg;

    // Default sizing of the point stores and the distance datapath
    localparam int MAX_POINTS_DEF = 64;
    localparam int DIST_WIDTH_DEF = 32;

    // Fixed widths of the transaction fields
    localparam int IDX_FIELD_W  = 6;
    localparam int DIST_FIELD_W = 32;

    // Operation codes
    localparam logic [1:0] OP_PUSH    = 2'd0;
    localparam logic [1:0] OP_READ    = 2'd1;
    localparam logic [1:0] OP_RESTART = 2'd2;

    // Read status codes
    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_TOO_FEW  = 2'd1;
    localparam logic [1:0] ST_BAD_INDEX = 2'd2;

    typedef struct packed {
        logic [1:0]              op;
        logic [IDX_FIELD_W-1:0]  entry_index;
        logic [DIST_FIELD_W-1:0] distance;
        logic                    row_last;
    } slink_in_t;

    typedef struct packed {
        logic [IDX_FIELD_W-1:0]  point_index;
        logic [IDX_FIELD_W-1:0]  merge_partner;
        logic [DIST_FIELD_W-1:0] merge_height;
        logic [1:0]              status;
    } slink_out_t;

    // Sequencer states
    typedef enum logic [3:0] {
        SQ_CLEAR,
        SQ_IDLE,
        SQ_AB_RD,
        SQ_AB_MIN,
        SQ_AB_CMP,
        SQ_AB_UPD,
        SQ_FIN_W,
        SQ_FIN_RD,
        SQ_FIN_RP,
        SQ_FIN_CMP,
        SQ_RD_RD,
        SQ_RD_OUT
    } slink_state_t;

endpackage

// File: rtl/core/slink_single_linkage_pointer_core.sv
// Top level of the incremental single-linkage clustering core (pointer form).
//
// Input channel s_valid/s_ready/s_data carries one operation per transaction:
// push a distance of the current row, read an entry, or restart. The result
// channel m_valid/m_ready/m_data carries one transaction for every read and
// nothing for the other operations.
// A push brings s_ready back only after its AB_RD, AB_MIN, AB_CMP and AB_UPD
// steps. A push that ends a row of new point k at position i runs these steps
// again for every skipped slot (k-1-i), enters the new point (FIN_W) and then
// walks over all earlier points (FIN_RD, FIN_RP, FIN_CMP each) to repoint them;
// every step runs through the one shared compare unit and the single read port
// of each store. A read shows its result after its read and output steps (only
// the output step when it is refused), and s_ready returns in that same cycle.
// After reset, and after a restart, a sweep over all MAX_POINTS row entries
// invalidates the row store; s_ready stays low meanwhile and the core then holds
// one point. If the receiver stalls, a finished read waits in the output register
// and a following read holds in its output step until the slot frees.
module slink_single_linkage_pointer_core #(
    parameter int MAX_POINTS = slink_pkg::MAX_POINTS_DEF,
    parameter int DIST_WIDTH = slink_pkg::DIST_WIDTH_DEF
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_valid,
    output logic                   s_ready,
    input  slink_pkg::slink_in_t   s_data,
    output logic                   m_valid,
    input  logic                   m_ready,
    output slink_pkg::slink_out_t  m_data
);

    import slink_pkg::*;

    localparam int IDX_W = $clog2(MAX_POINTS);
    localparam int CNT_W = $clog2(MAX_POINTS + 1);
    localparam int EXT_W = (CNT_W > IDX_FIELD_W) ? CNT_W : IDX_FIELD_W;
    localparam int ROW_W = IDX_W + DIST_WIDTH;
    localparam logic [DIST_WIDTH-1:0] DIST_INF = '1;

    // Sequencer and working registers
    slink_state_t          state_reg,  state_next;
    logic [CNT_W-1:0]      count_reg,  count_next;
    logic [IDX_W-1:0]      rowpos_reg, rowpos_next;
    logic [IDX_W-1:0]      cur_reg,    cur_next;
    logic [IDX_W-1:0]      ptr_reg,    ptr_next;
    logic [DIST_WIDTH-1:0] ht_reg,     ht_next;
    logic [DIST_WIDTH-1:0] r_reg,      r_next;
    logic [DIST_WIDTH-1:0] dist_reg,   dist_next;
    logic                  flush_reg,  flush_next;
    logic [IDX_FIELD_W-1:0] entry_reg, entry_next;
    logic [1:0]            status_reg, status_next;
    logic                  m_valid_reg, m_valid_next;
    slink_out_t            m_data_reg, m_data_next;

    // Memory ports
    logic                  ptr_we, ht_we, row_we;
    logic [IDX_W-1:0]      ptr_waddr, ht_waddr, row_waddr;
    logic [IDX_W-1:0]      ptr_raddr, ht_raddr, row_raddr;
    logic [IDX_W-1:0]      ptr_wdata, ptr_rdata;
    logic [DIST_WIDTH-1:0] ht_wdata, ht_rdata;
    logic [ROW_W-1:0]      row_wdata, row_rdata;

    // Shared compare unit
    logic [DIST_WIDTH-1:0] cmp_a, cmp_b, cmp_min;
    logic                  cmp_lt;

    logic [IDX_W-1:0]      k_idx;
    logic [DIST_WIDTH-1:0] row_eff;
    logic                  push_ok;
    logic [CNT_W-1:0]      cur_inc;

    slink_ram #(.WIDTH(IDX_W), .DEPTH(MAX_POINTS)) u_ptr_ram (
        .aclk  (aclk),
        .we    (ptr_we),
        .waddr (ptr_waddr),
        .wdata (ptr_wdata),
        .raddr (ptr_raddr),
        .rdata (ptr_rdata)
    );

    slink_ram #(.WIDTH(DIST_WIDTH), .DEPTH(MAX_POINTS)) u_ht_ram (
        .aclk  (aclk),
        .we    (ht_we),
        .waddr (ht_waddr),
        .wdata (ht_wdata),
        .raddr (ht_raddr),
        .rdata (ht_rdata)
    );

    // Row entries carry the tag of the row that wrote them; other tags read as infinity
    slink_ram #(.WIDTH(ROW_W), .DEPTH(MAX_POINTS)) u_row_ram (
        .aclk  (aclk),
        .we    (row_we),
        .waddr (row_waddr),
        .wdata (row_wdata),
        .raddr (row_raddr),
        .rdata (row_rdata)
    );

    slink_cmp #(.WIDTH(DIST_WIDTH)) u_cmp (
        .a      (cmp_a),
        .b      (cmp_b),
        .a_lt_b (cmp_lt),
        .min_ab (cmp_min)
    );

    // Derived values
    assign k_idx   = IDX_W'(count_reg);
    assign row_eff = (row_rdata[ROW_W-1:DIST_WIDTH] == k_idx) ?
                     row_rdata[DIST_WIDTH-1:0] : DIST_INF;
    assign push_ok = (count_reg < CNT_W'(MAX_POINTS)) && (CNT_W'(rowpos_reg) < count_reg);
    assign cur_inc = CNT_W'(cur_reg) + CNT_W'(1);

    assign s_ready = (state_reg == SQ_IDLE);
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // State register and control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= SQ_CLEAR;
            count_reg   <= CNT_W'(1);
            rowpos_reg  <= '0;
            cur_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            rowpos_reg  <= rowpos_next;
            cur_reg     <= cur_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Datapath registers
    always_ff @(posedge aclk) begin
        ptr_reg    <= ptr_next;
        ht_reg     <= ht_next;
        r_reg      <= r_next;
        dist_reg   <= dist_next;
        flush_reg  <= flush_next;
        entry_reg  <= entry_next;
        status_reg <= status_next;
        m_data_reg <= m_data_next;
    end

    // Sequencer: next state, memory ports and compare operands
    always_comb begin
        state_next   = state_reg;
        count_next   = count_reg;
        rowpos_next  = rowpos_reg;
        cur_next     = cur_reg;
        ptr_next     = ptr_reg;
        ht_next      = ht_reg;
        r_next       = r_reg;
        dist_next    = dist_reg;
        flush_next   = flush_reg;
        entry_next   = entry_reg;
        status_next  = status_reg;
        m_data_next  = m_data_reg;
        m_valid_next = m_valid_reg && !m_ready;

        ptr_we    = 1'b0;
        ptr_waddr = cur_reg;
        ptr_wdata = k_idx;
        ht_we     = 1'b0;
        ht_waddr  = cur_reg;
        ht_wdata  = r_reg;
        row_we    = 1'b0;
        row_waddr = ptr_reg;
        row_wdata = {k_idx, cmp_min};
        ptr_raddr = cur_reg;
        ht_raddr  = cur_reg;
        row_raddr = cur_reg;
        cmp_a     = ht_reg;
        cmp_b     = r_reg;

        case (state_reg)
            SQ_CLEAR: begin
                // Invalidate one row entry a cycle; seed point zero on the first
                row_we    = 1'b1;
                row_waddr = cur_reg;
                row_wdata = '0;
                if (cur_reg == '0) begin
                    ptr_we    = 1'b1;
                    ptr_waddr = '0;
                    ptr_wdata = '0;
                    ht_we     = 1'b1;
                    ht_waddr  = '0;
                    ht_wdata  = DIST_INF;
                end
                if (cur_reg == IDX_W'(MAX_POINTS - 1)) begin
                    cur_next   = '0;
                    state_next = SQ_IDLE;
                end else begin
                    cur_next = cur_reg + IDX_W'(1);
                end
            end
            SQ_IDLE: begin
                if (s_valid) begin
                    case (s_data.op)
                        OP_PUSH: begin
                            if (push_ok) begin
                                cur_next   = rowpos_reg;
                                dist_next  = DIST_WIDTH'(s_data.distance);
                                flush_next = s_data.row_last ||
                                             (CNT_W'(rowpos_reg) + CNT_W'(1) >= count_reg);
                                state_next = SQ_AB_RD;
                            end
                        end
                        OP_READ: begin
                            entry_next = s_data.entry_index;
                            if (count_reg < CNT_W'(2)) begin
                                status_next = ST_TOO_FEW;
                                state_next  = SQ_RD_OUT;
                            end else if (EXT_W'(s_data.entry_index) >= EXT_W'(count_reg)) begin
                                status_next = ST_BAD_INDEX;
                                state_next  = SQ_RD_OUT;
                            end else begin
                                status_next = ST_OK;
                                cur_next    = IDX_W'(s_data.entry_index);
                                state_next  = SQ_RD_RD;
                            end
                        end
                        OP_RESTART: begin
                            count_next  = CNT_W'(1);
                            rowpos_next = '0;
                            cur_next    = '0;
                            state_next  = SQ_CLEAR;
                        end
                        default: begin
                            // drop the unused operation code
                        end
                    endcase
                end
            end
            SQ_AB_RD: begin
                state_next = SQ_AB_MIN;
            end
            SQ_AB_MIN: begin
                // Fold the incoming distance into the row slot
                cmp_a      = row_eff;
                cmp_b      = dist_reg;
                r_next     = cmp_min;
                ptr_next   = ptr_rdata;
                ht_next    = ht_rdata;
                state_next = SQ_AB_CMP;
            end
            SQ_AB_CMP: begin
                // Repoint the earlier point when its height is not below the row value
                cmp_a     = ht_reg;
                cmp_b     = r_reg;
                row_raddr = ptr_reg;
                if (!cmp_lt) begin
                    ptr_we    = 1'b1;
                    ptr_wdata = k_idx;
                    ht_we     = 1'b1;
                    ht_wdata  = r_reg;
                    r_next    = ht_reg;
                end
                state_next = SQ_AB_UPD;
            end
            SQ_AB_UPD: begin
                // Forward minimum into the row slot of the pointer target
                cmp_a     = row_eff;
                cmp_b     = r_reg;
                row_we    = 1'b1;
                row_waddr = ptr_reg;
                row_wdata = {k_idx, cmp_min};
                if (flush_reg) begin
                    if (cur_inc < count_reg) begin
                        cur_next   = cur_reg + IDX_W'(1);
                        dist_next  = DIST_INF;
                        state_next = SQ_AB_RD;
                    end else begin
                        state_next = SQ_FIN_W;
                    end
                end else begin
                    rowpos_next = cur_reg + IDX_W'(1);
                    state_next  = SQ_IDLE;
                end
            end
            SQ_FIN_W: begin
                // Enter the new point as its own pointer at infinite height
                ptr_we     = 1'b1;
                ptr_waddr  = k_idx;
                ptr_wdata  = k_idx;
                ht_we      = 1'b1;
                ht_waddr   = k_idx;
                ht_wdata   = DIST_INF;
                cur_next   = '0;
                state_next = SQ_FIN_RD;
            end
            SQ_FIN_RD: begin
                state_next = SQ_FIN_RP;
            end
            SQ_FIN_RP: begin
                // Fetch the height of the pointer target
                ht_raddr   = ptr_rdata;
                ptr_next   = ptr_rdata;
                ht_next    = ht_rdata;
                state_next = SQ_FIN_CMP;
            end
            SQ_FIN_CMP: begin
                cmp_a = ht_reg;
                cmp_b = ht_rdata;
                if (!cmp_lt) begin
                    ptr_we    = 1'b1;
                    ptr_wdata = k_idx;
                end
                if (cur_inc < count_reg) begin
                    cur_next   = cur_reg + IDX_W'(1);
                    state_next = SQ_FIN_RD;
                end else begin
                    count_next  = count_reg + CNT_W'(1);
                    rowpos_next = '0;
                    state_next  = SQ_IDLE;
                end
            end
            SQ_RD_RD: begin
                state_next = SQ_RD_OUT;
            end
            SQ_RD_OUT: begin
                // Hold until the output register is free
                if (!m_valid_reg || m_ready) begin
                    m_valid_next              = 1'b1;
                    m_data_next.point_index   = entry_reg;
                    m_data_next.status        = status_reg;
                    if (status_reg == ST_OK) begin
                        m_data_next.merge_partner = IDX_FIELD_W'(ptr_rdata);
                        m_data_next.merge_height  = DIST_FIELD_W'(ht_rdata);
                    end else begin
                        m_data_next.merge_partner = '0;
                        m_data_next.merge_height  = '0;
                    end
                    state_next = SQ_IDLE;
                end
            end
            default: begin
                state_next = SQ_IDLE;
            end
        endcase
    end

    // Point count stays within one and the store depth
    assert property (@(posedge aclk) disable iff (!aresetn)
        (count_reg >= CNT_W'(1)) && (count_reg <= CNT_W'(MAX_POINTS)))
        else $error("point count out of range");

    // Row position stays below the point count
    assert property (@(posedge aclk) disable iff (!aresetn)
        CNT_W'(rowpos_reg) < count_reg)
        else $error("row position beyond point count");

    // Earlier points only point at points already held
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == SQ_AB_CMP) |-> (CNT_W'(ptr_reg) < count_reg))
        else $error("pointer beyond current point");

    // A result only appears after the read step
    assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(state_reg == SQ_RD_OUT))
        else $error("result raised outside read step");

endmodule

// File: rtl/core/slink_ram.sv
// Generic single-write, single-read RAM with registered read data.
module slink_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port
    always_ff @(posedge aclk) begin
        rdata <= mem[raddr];
    end

endmodule

// File: rtl/core/slink_cmp.sv
// Shared unsigned magnitude compare and minimum unit.
module slink_cmp #(
    parameter int WIDTH = 32
) (
    input  logic [WIDTH-1:0] a,
    input  logic [WIDTH-1:0] b,
    output logic             a_lt_b,
    output logic [WIDTH-1:0] min_ab
);

    // Compare once, select the smaller operand
    assign a_lt_b = (a < b);
    assign min_ab = a_lt_b ? a : b;

endmodule

// File: tb/tb_top.sv
// Self-checking testbench for the single-linkage pointer core: predictor, stimulus and checker.
module tb_top;
    import slink_pkg::*;

    localparam int NPTS = MAX_POINTS_DEF;
    localparam logic [DIST_FIELD_W-1:0] DIST_INF = '1;
    localparam logic [1:0] OP_UNUSED = 2'd3;
    localparam int TAIL_CYCLES = 600;
    localparam int CYCLE_LIMIT = 1_500_000;
    localparam int MAX_PRINTS  = 40;

    logic       aclk    = 1'b0;
    logic       aresetn = 1'b0;
    logic       s_valid = 1'b0;
    logic       s_ready;
    slink_in_t  s_data  = '0;
    logic       m_valid;
    logic       m_ready = 1'b0;
    slink_out_t m_data;

    // Predicted cluster state of the core
    logic [IDX_FIELD_W-1:0]  link_ptr    [NPTS];
    logic [DIST_FIELD_W-1:0] link_height [NPTS];
    logic [DIST_FIELD_W-1:0] row_min     [NPTS];
    logic [6:0]              n_points;
    logic [5:0]              row_pos;

    slink_out_t expected_reads [$];

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int n_errors       = 0;
    int n_sent         = 0;
    int n_checked      = 0;
    int n_rows         = 0;
    int n_restarts     = 0;
    int cycle_count    = 0;

    slink_single_linkage_pointer_core dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    // Clock generation
    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    // Abort the run if it hangs
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("FAILED: results differ");
            $finish;
        end
    end

    task automatic report_mismatch(input string what);
        n_errors++;
        if (n_errors <= MAX_PRINTS)
            $display("mismatch at cycle %0d: %s", cycle_count, what);
    endtask

    // ---------------------------------------------------------------- predictor

    function automatic logic [DIST_FIELD_W-1:0] dist_min(input logic [DIST_FIELD_W-1:0] a,
                                                         input logic [DIST_FIELD_W-1:0] b);
        return (a < b) ? a : b;
    endfunction

    function automatic void clear_row_min();
        foreach (row_min[j])
            row_min[j] = DIST_INF;
    endfunction

    function automatic void restart_points();
        foreach (link_ptr[j]) begin
            link_ptr[j]    = '0;
            link_height[j] = '0;
        end
        clear_row_min();
        link_height[0] = DIST_INF;
        n_points       = 7'd1;
        row_pos        = '0;
    endfunction

    // Fold distance d from point i into the row of new point k
    function automatic void fold_distance(input int i, input int k,
                                          input logic [DIST_FIELD_W-1:0] d);
        logic [DIST_FIELD_W-1:0] r;
        int p;
        r = dist_min(row_min[i], d);
        p = int'(link_ptr[i]);
        if (link_height[i] >= r) begin
            row_min[p]     = dist_min(row_min[p], link_height[i]);
            link_height[i] = r;
            link_ptr[i]    = k[IDX_FIELD_W-1:0];
        end else begin
            row_min[p] = dist_min(row_min[p], r);
        end
    endfunction

    // Add point k and repoint every earlier point that now merges later
    function automatic void close_row(input int k);
        link_ptr[k]    = k[IDX_FIELD_W-1:0];
        link_height[k] = DIST_INF;
        for (int i = 0; i < k; i++) begin
            if (link_height[i] >= link_height[link_ptr[i]])
                link_ptr[i] = k[IDX_FIELD_W-1:0];
        end
        clear_row_min();
        n_points = 7'(k + 1);
        row_pos  = '0;
        n_rows++;
    endfunction

    // Advance the prediction by one accepted transaction; return 0 if the core ignores it
    function automatic bit predict_item(input slink_in_t item);
        slink_out_t res;
        int k;
        int i;
        k = int'(n_points);
        i = int'(row_pos);
        case (item.op)
            OP_PUSH: begin
                if (k >= NPTS || i >= k)
                    return 1'b0;
                fold_distance(i, k, item.distance);
                if (item.row_last || i + 1 >= k) begin
                    for (int j = i + 1; j < k; j++)
                        fold_distance(j, k, DIST_INF);
                    close_row(k);
                end else begin
                    row_pos = 6'(i + 1);
                end
                return 1'b1;
            end
            OP_READ: begin
                res.point_index   = item.entry_index;
                res.merge_partner = '0;
                res.merge_height  = '0;
                if (n_points < 7'd2) begin
                    res.status = ST_TOO_FEW;
                end else if ({1'b0, item.entry_index} >= n_points) begin
                    res.status = ST_BAD_INDEX;
                end else begin
                    res.status        = ST_OK;
                    res.merge_partner = link_ptr[item.entry_index];
                    res.merge_height  = link_height[item.entry_index];
                end
                expected_reads = {expected_reads, res};
                return 1'b1;
            end
            OP_RESTART: begin
                restart_points();
                n_restarts++;
                return 1'b1;
            end
            default: return 1'b0;
        endcase
    endfunction

    // ---------------------------------------------------------------- result side

    task automatic check_read(input slink_out_t got);
        slink_out_t want;
        want = expected_reads.pop_front();
        n_checked++;
        if (got.point_index !== want.point_index)
            report_mismatch($sformatf("point_index got %0d want %0d",
                                      got.point_index, want.point_index));
        if (got.merge_partner !== want.merge_partner)
            report_mismatch($sformatf("entry %0d merge_partner got %0d want %0d",
                                      want.point_index, got.merge_partner, want.merge_partner));
        if (got.merge_height !== want.merge_height)
            report_mismatch($sformatf("entry %0d merge_height got %h want %h",
                                      want.point_index, got.merge_height, want.merge_height));
        if (got.status !== want.status)
            report_mismatch($sformatf("entry %0d status got %0d want %0d",
                                      want.point_index, got.status, want.status));
    endtask

    // Stall the result channel at random and check every accepted transaction
    always @(posedge aclk) begin
        m_ready <= ($urandom_range(99) >= recv_stall_pct);
        if (aresetn && m_valid && m_ready) begin
            if (expected_reads.size() == 0)
                report_mismatch("result transaction with nothing expected");
            else
                check_read(m_data);
        end
    end

    // ---------------------------------------------------------------- input side

    task automatic send_item(input slink_in_t item);
        // Hold off for a random gap, then present the transaction until accepted
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= item;
        do @(posedge aclk); while (!s_ready);
        if (predict_item(item))
            n_sent++;
    endtask

    task automatic wait_results_drained();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (expected_reads.size() != 0)
            @(posedge aclk);
    endtask

    function automatic slink_in_t push_item(input logic [DIST_FIELD_W-1:0] d, input logic last);
        slink_in_t it;
        it.op          = OP_PUSH;
        it.entry_index = IDX_FIELD_W'($urandom);
        it.distance    = d;
        it.row_last    = last;
        return it;
    endfunction

    function automatic slink_in_t read_item(input logic [IDX_FIELD_W-1:0] idx);
        slink_in_t it;
        it.op          = OP_READ;
        it.entry_index = idx;
        it.distance    = $urandom;
        it.row_last    = 1'($urandom);
        return it;
    endfunction

    function automatic slink_in_t other_item(input logic [1:0] op);
        slink_in_t it;
        it.op          = op;
        it.entry_index = IDX_FIELD_W'($urandom);
        it.distance    = $urandom;
        it.row_last    = 1'($urandom);
        return it;
    endfunction

    // Small ranges give plenty of equal heights; the ends of the range come up often
    function automatic logic [DIST_FIELD_W-1:0] rand_distance();
        int unsigned pick;
        pick = $urandom_range(99);
        if (pick < 30) return $urandom_range(7);
        if (pick < 55) return $urandom_range(255);
        if (pick < 80) return $urandom;
        if (pick < 88) return '0;
        if (pick < 92) return DIST_INF - 1;
        return DIST_INF;
    endfunction

    task automatic send_random_read();
        logic [IDX_FIELD_W-1:0] idx;
        if ($urandom_range(99) < 80)
            idx = IDX_FIELD_W'($urandom_range(n_points - 1));
        else
            idx = IDX_FIELD_W'($urandom_range(NPTS - 1));
        send_item(read_item(idx));
    endtask

    // Send one row for the next point, sometimes cut short or without its end marker
    task automatic send_row(input int early_pct, input int missing_pct, input int read_pct);
        int  k;
        int  len;
        int  j;
        bit  missing;
        k = int'(n_points);
        if (k >= NPTS) begin
            send_item(push_item(rand_distance(), 1'b1));
            return;
        end
        len     = ($urandom_range(99) < early_pct) ? $urandom_range(k, 1) : k;
        missing = (len == k) && ($urandom_range(99) < missing_pct);
        for (j = 0; j < len; j++) begin
            if ($urandom_range(99) < read_pct)
                send_random_read();
            send_item(push_item(rand_distance(), (j == len - 1) && !missing));
        end
    endtask

    // ---------------------------------------------------------------- tests

    task automatic test_directed_cases();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        // Reads with a single point held
        send_item(read_item('0));
        send_item(read_item(IDX_FIELD_W'(NPTS - 1)));
        // Unused operation with every field at its top
        send_item('{op: OP_UNUSED, entry_index: '1, distance: '1, row_last: 1'b1});
        // First row, zero distance
        send_item(push_item('0, 1'b1));
        send_item(read_item(6'd0));
        send_item(read_item(6'd1));
        send_item(read_item(6'd2));
        send_item(read_item(IDX_FIELD_W'(NPTS - 1)));
        // Second row with infinity and zero
        send_item(push_item(DIST_INF, 1'b0));
        send_item(push_item('0, 1'b1));
        // Row cut short by an early end marker
        send_item(push_item(32'd5, 1'b1));
        // Row without its end marker, read midway
        send_item(push_item(32'd7, 1'b0));
        send_item(push_item(32'd7, 1'b0));
        send_item(read_item(6'd1));
        send_item(push_item(DIST_INF, 1'b0));
        send_item(push_item(DIST_INF - 1, 1'b0));
        send_item(read_item(6'd0));
        send_item(read_item(6'd2));
        send_item(read_item(6'd3));
        send_item(read_item(6'd4));
        send_item(read_item(6'd5));
        // Restart behaves like reset
        send_item(other_item(OP_RESTART));
        send_item(read_item(6'd0));
    endtask

    task automatic test_fill_to_capacity();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        send_item(other_item(OP_RESTART));
        while (n_points < NPTS) begin
            if ($urandom_range(3) == 0)
                send_random_read();
            send_item(push_item(rand_distance(), 1'b1));
        end
        // Pushes into a full store are dropped
        repeat (4) send_item(push_item(rand_distance(), 1'($urandom)));
        send_item(read_item(IDX_FIELD_W'(NPTS - 1)));
        send_item(read_item(6'd0));
        repeat (6) send_random_read();
        send_item(other_item(OP_RESTART));
    endtask

    task automatic test_random_clusters(input int n_items, input int idle_pct,
                                        input int stall_pct);
        int stop_at;
        int cap;
        int pick;
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        stop_at = n_sent + n_items;
        cap     = $urandom_range(20, 4);
        while (n_sent < stop_at) begin
            pick = $urandom_range(99);
            if (n_points > cap) begin
                send_item(other_item(OP_RESTART));
                cap = ($urandom_range(9) == 0) ? $urandom_range(48, 30) : $urandom_range(20, 3);
            end else if (pick < 70) begin
                send_row(10, 8, 15);
            end else if (pick < 85) begin
                repeat ($urandom_range(5, 1)) send_random_read();
            end else if (pick < 90) begin
                send_item(other_item(OP_UNUSED));
            end else if (pick < 96) begin
                send_item(push_item(rand_distance(), 1'($urandom)));
            end else begin
                send_item(other_item(OP_RESTART));
            end
        end
    endtask

    task automatic test_drain_pause();
        send_idle_pct  = 0;
        recv_stall_pct = 54;
        send_row(0, 0, 30);
        repeat (4) send_random_read();
        // Hold the sender until every read has been answered
        wait_results_drained();
        repeat (4) send_random_read();
        send_row(0, 0, 30);
        send_random_read();
    endtask

    initial begin
        restart_points();
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;

        test_directed_cases();
        test_fill_to_capacity();
        test_random_clusters(120, 0, 0);
        test_random_clusters(120, 54, 0);
        test_random_clusters(120, 0, 54);
        test_random_clusters(120, 29, 29);
        test_drain_pause();

        // Drain, then allow for the longest row walk or clearing sweep
        wait_results_drained();
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (expected_reads.size() != 0)
            report_mismatch($sformatf("%0d reads never answered", expected_reads.size()));

        $display("covered %0d transactions: %0d rows closed, %0d restarts, %0d reads checked",
                 n_sent, n_rows, n_restarts, n_checked);
        $display("idle phases: none, sender gaps, receiver stalls, both; one drain pause");
        if (n_errors == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule
